// ----- rtl/kdq_pkg.sv -----
// Package with the transfer types, operation and status codes and defaults of the keyed deque store.
`timescale 1ns / 1ps
`default_nettype none
package kdq_pkg;

	localparam int DEPTH_DEF      = 64;
	localparam int COORD_BITS_DEF = 10;

	localparam logic [2:0] FN_PUSH_BACK  = 3'd0;
	localparam logic [2:0] FN_PUSH_FRONT = 3'd1;
	localparam logic [2:0] FN_POP_FRONT  = 3'd2;
	localparam logic [2:0] FN_POP_BACK   = 3'd3;
	localparam logic [2:0] FN_REMOVE     = 3'd4;
	localparam logic [2:0] FN_CLEAR      = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_FULL     = 2'd3;

	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] item_value;
		logic [9:0]  pos_x;
		logic [9:0]  pos_y;
	} req_t;

	typedef struct packed {
		logic [31:0] out_value;
		logic [1:0]  status;
		logic [6:0]  entry_count;
		logic        is_empty;
	} rsp_t;

	typedef struct packed {
		logic load;
		logic from_lo;
		logic from_hi;
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/kdq_cell.sv -----
// One storage cell of the deque chain with its position compare.
`timescale 1ns / 1ps
`default_nettype none
module kdq_cell #(
	parameter int COORD_BITS = kdq_pkg::COORD_BITS_DEF
) (
	input  wire                    clk,
	input  kdq_pkg::cell_ctl_t     ctl,
	input  wire [31:0]             in_value,
	input  wire [COORD_BITS-1:0]   in_x,
	input  wire [COORD_BITS-1:0]   in_y,
	input  wire [31:0]             lo_value,
	input  wire [COORD_BITS-1:0]   lo_x,
	input  wire [COORD_BITS-1:0]   lo_y,
	input  wire [31:0]             hi_value,
	input  wire [COORD_BITS-1:0]   hi_x,
	input  wire [COORD_BITS-1:0]   hi_y,
	input  wire [COORD_BITS-1:0]   key_x,
	input  wire [COORD_BITS-1:0]   key_y,
	output logic [31:0]            value,
	output logic [COORD_BITS-1:0]  pos_x,
	output logic [COORD_BITS-1:0]  pos_y,
	output logic                   match
);

	logic [31:0]           value_q;
	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			value_q <= in_value;
			x_q     <= in_x;
			y_q     <= in_y;
		end else if (ctl.from_lo) begin
			value_q <= lo_value;
			x_q     <= lo_x;
			y_q     <= lo_y;
		end else if (ctl.from_hi) begin
			value_q <= hi_value;
			x_q     <= hi_x;
			y_q     <= hi_y;
		end
	end

	assign value = value_q;
	assign pos_x = x_q;
	assign pos_y = y_q;
	assign match = (x_q == key_x) && (y_q == key_y);

endmodule
`default_nettype wire

// ----- rtl/keyed_deque_store_core.sv -----
// Top level of the keyed deque store: sequencer, cell chain and result register.
// Each operation runs through the sequencer states: the transfer in idle registers the
// operation and the position compares of all cells, and the execute state picks the entry,
// shifts the chain and loads the result register, waiting while a held result is stalled;
// the next request is taken only once the sequencer is back in idle, after that commit.
// Reset clears the entry count, the sequencer and the result valid; cell contents stay.
`timescale 1ns / 1ps
`default_nettype none
module keyed_deque_store_core #(
	parameter int DEPTH      = kdq_pkg::DEPTH_DEF,
	parameter int COORD_BITS = kdq_pkg::COORD_BITS_DEF
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            req_valid,
	output logic           req_stall,
	input  kdq_pkg::req_t  req,
	output logic           rsp_valid,
	input  wire            rsp_stall,
	output kdq_pkg::rsp_t  rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [0:0] {ST_IDLE, ST_EXEC} state_t;

	state_t                state_q;
	logic [CW-1:0]         count_q;
	logic                  rsp_valid_q;
	kdq_pkg::rsp_t         rsp_q;

	logic [2:0]            func_s1;
	logic [31:0]           value_s1;
	logic [COORD_BITS-1:0] x_s1;
	logic [COORD_BITS-1:0] y_s1;
	logic [DEPTH-1:0]      match_s1;

	logic [COORD_BITS-1:0] key_x;
	logic [COORD_BITS-1:0] key_y;
	logic [DEPTH-1:0]      match;
	logic [DEPTH-1:0]      occ;
	logic [31:0]           cell_value [DEPTH];
	logic [COORD_BITS-1:0] cell_x     [DEPTH];
	logic [COORD_BITS-1:0] cell_y     [DEPTH];
	kdq_pkg::cell_ctl_t    cell_ctl   [DEPTH];

	logic                  accept;
	logic                  commit;
	logic                  full;
	logic                  empty;
	logic [DEPTH-1:0]      sel_vec;
	logic [DEPTH-1:0]      sel_neg;
	logic [DEPTH-1:0]      take;
	logic [DEPTH-1:0]      shift_mask;
	logic [DEPTH-1:0]      back_slot;
	logic                  do_take;
	logic                  do_push_back;
	logic                  do_push_front;
	logic [CW-1:0]         count_nxt;
	logic [1:0]            status_nxt;
	logic [31:0]           out_value_nxt;

	assign key_x = COORD_BITS'(req.pos_x);
	assign key_y = COORD_BITS'(req.pos_y);

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && !req_stall;
	assign commit    = (state_q == ST_EXEC) && !(rsp_valid_q && rsp_stall);

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [31:0]           lo_value;
			logic [COORD_BITS-1:0] lo_x;
			logic [COORD_BITS-1:0] lo_y;
			logic [31:0]           hi_value;
			logic [COORD_BITS-1:0] hi_x;
			logic [COORD_BITS-1:0] hi_y;

			if (gi == 0) begin : g_first
				assign lo_value = value_s1;
				assign lo_x     = x_s1;
				assign lo_y     = y_s1;
			end else begin : g_mid_lo
				assign lo_value = cell_value[gi-1];
				assign lo_x     = cell_x[gi-1];
				assign lo_y     = cell_y[gi-1];
			end

			if (gi == DEPTH - 1) begin : g_last
				assign hi_value = '0;
				assign hi_x     = '0;
				assign hi_y     = '0;
			end else begin : g_mid_hi
				assign hi_value = cell_value[gi+1];
				assign hi_x     = cell_x[gi+1];
				assign hi_y     = cell_y[gi+1];
			end

			assign occ[gi] = (count_q > CW'(gi));

			kdq_cell #(
				.COORD_BITS(COORD_BITS)
			) u_cell (
				.clk      (clk),
				.ctl      (cell_ctl[gi]),
				.in_value (value_s1),
				.in_x     (x_s1),
				.in_y     (y_s1),
				.lo_value (lo_value),
				.lo_x     (lo_x),
				.lo_y     (lo_y),
				.hi_value (hi_value),
				.hi_x     (hi_x),
				.hi_y     (hi_y),
				.key_x    (key_x),
				.key_y    (key_y),
				.value    (cell_value[gi]),
				.pos_x    (cell_x[gi]),
				.pos_y    (cell_y[gi]),
				.match    (match[gi])
			);
		end
	endgenerate

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign back_slot = ~occ & {occ[DEPTH-2:0], 1'b1};

	// The lowest set bit of the selection vector marks the entry taken, and every cell
	// from there upwards pulls its upper neighbour in.
	always_comb begin
		sel_vec       = '0;
		do_take       = 1'b0;
		do_push_back  = 1'b0;
		do_push_front = 1'b0;
		status_nxt    = kdq_pkg::ST_OK;
		count_nxt     = count_q;
		case (func_s1)
			kdq_pkg::FN_PUSH_BACK, kdq_pkg::FN_PUSH_FRONT: begin
				if (full) begin
					status_nxt = kdq_pkg::ST_FULL;
				end else begin
					do_push_back  = (func_s1 == kdq_pkg::FN_PUSH_BACK);
					do_push_front = (func_s1 == kdq_pkg::FN_PUSH_FRONT);
					count_nxt     = count_q + 1'b1;
				end
			end
			kdq_pkg::FN_POP_FRONT, kdq_pkg::FN_POP_BACK, kdq_pkg::FN_REMOVE: begin
				if (func_s1 == kdq_pkg::FN_POP_FRONT) begin
					sel_vec = occ;
				end else if (func_s1 == kdq_pkg::FN_POP_BACK) begin
					sel_vec = occ & ~(occ >> 1);
				end else begin
					sel_vec = match_s1 & occ;
				end
				if (empty) begin
					status_nxt = kdq_pkg::ST_EMPTY;
				end else if (sel_vec == '0) begin
					status_nxt = kdq_pkg::ST_NOTFOUND;
				end else begin
					do_take   = 1'b1;
					count_nxt = count_q - 1'b1;
				end
			end
			kdq_pkg::FN_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase
	end

	assign sel_neg    = ~sel_vec + 1'b1;
	assign take       = do_take ? (sel_vec & sel_neg) : '0;
	assign shift_mask = do_take ? (sel_vec | sel_neg) : '0;

	always_comb begin
		out_value_nxt = '0;
		for (int i = 0; i < DEPTH; i++) begin
			out_value_nxt = out_value_nxt | (take[i] ? cell_value[i] : 32'd0);
		end
	end

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			cell_ctl[i].load    = commit && do_push_back && back_slot[i];
			cell_ctl[i].from_lo = commit && do_push_front;
			cell_ctl[i].from_hi = commit && shift_mask[i];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= req.func;
			value_s1 <= req.item_value;
			x_s1     <= key_x;
			y_s1     <= key_y;
			match_s1 <= match;
		end
		if (commit) begin
			rsp_q.out_value   <= out_value_nxt;
			rsp_q.status      <= status_nxt;
			rsp_q.entry_count <= 7'(count_nxt);
			rsp_q.is_empty    <= (count_nxt == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
					if (rsp_valid_q && !rsp_stall) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_EXEC: begin
					if (commit) begin
						count_q     <= count_nxt;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("Entry count exceeds the store depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC) && req_stall)
		else $error("Accepted request did not start an operation.");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("Result raised without an operation in progress.");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.is_empty == (count_q == '0)))
		else $error("Result empty flag disagrees with the entry count.");
`endif

endmodule
`default_nettype wire

// ----- test/tb_keyed_deque_store_core.sv -----
// Self-checking testbench for the keyed deque store: directed table, then random phases.
`timescale 1ns / 1ps
module tb_keyed_deque_store_core;
	import kdq_pkg::*;

	localparam int STORE_DEPTH  = DEPTH_DEF;
	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 8;

	localparam logic [2:0] FN_RSVD6 = 3'd6;
	localparam logic [2:0] FN_RSVD7 = 3'd7;

	localparam int MIX_EVEN  = 0;
	localparam int MIX_FILL  = 1;
	localparam int MIX_DRAIN = 2;

	localparam logic [2:0] FUNC_ORDER [8] = '{FN_PUSH_BACK, FN_PUSH_FRONT, FN_POP_FRONT,
		FN_POP_BACK, FN_REMOVE, FN_CLEAR, FN_RSVD6, FN_RSVD7};
	localparam int MIX_CUTS [3][8] = '{
		'{22, 44, 55, 66, 94, 96, 98, 100},
		'{42, 84, 87, 90, 98, 98, 99, 100},
		'{4, 8, 38, 68, 94, 96, 98, 100}
	};

	typedef struct packed {
		logic [31:0] value;
		logic [9:0]  x;
		logic [9:0]  y;
	} slot_t;

	typedef struct packed {
		req_t op;
		logic typed;
		rsp_t want;
	} row_t;

	localparam rsp_t NO_WANT = '0;

	localparam row_t DIRECTED [22] = '{
		'{'{FN_POP_FRONT, 32'h0, 10'h0, 10'h0}, 1'b1, '{32'h0, ST_EMPTY, 7'd0, 1'b1}},
		'{'{FN_POP_BACK, 32'h0, 10'h0, 10'h0}, 1'b1, '{32'h0, ST_EMPTY, 7'd0, 1'b1}},
		'{'{FN_REMOVE, 32'h0, 10'h3ff, 10'h3ff}, 1'b1, '{32'h0, ST_EMPTY, 7'd0, 1'b1}},
		'{'{FN_CLEAR, 32'h0, 10'h0, 10'h0}, 1'b1, '{32'h0, ST_OK, 7'd0, 1'b1}},
		'{'{FN_RSVD6, 32'hffffffff, 10'h3ff, 10'h3ff}, 1'b1, '{32'h0, ST_OK, 7'd0, 1'b1}},
		'{'{FN_RSVD7, 32'hffffffff, 10'h3ff, 10'h3ff}, 1'b1, '{32'h0, ST_OK, 7'd0, 1'b1}},
		'{'{FN_PUSH_BACK, 32'hffffffff, 10'h3ff, 10'h3ff}, 1'b1, '{32'h0, ST_OK, 7'd1, 1'b0}},
		'{'{FN_PUSH_FRONT, 32'h0, 10'h0, 10'h0}, 1'b1, '{32'h0, ST_OK, 7'd2, 1'b0}},
		'{'{FN_PUSH_BACK, 32'h55555555, 10'h155, 10'h2aa}, 1'b0, NO_WANT},
		'{'{FN_REMOVE, 32'h0, 10'h3ff, 10'h0}, 1'b1, '{32'h0, ST_NOTFOUND, 7'd3, 1'b0}},
		'{'{FN_REMOVE, 32'h0, 10'h3ff, 10'h3ff}, 1'b1, '{32'hffffffff, ST_OK, 7'd2, 1'b0}},
		'{'{FN_RSVD6, 32'h0, 10'h0, 10'h0}, 1'b0, NO_WANT},
		'{'{FN_POP_FRONT, 32'h0, 10'h0, 10'h0}, 1'b0, NO_WANT},
		'{'{FN_POP_BACK, 32'h0, 10'h0, 10'h0}, 1'b0, NO_WANT},
		'{'{FN_PUSH_FRONT, 32'haaaaaaaa, 10'h2aa, 10'h155}, 1'b0, NO_WANT},
		'{'{FN_PUSH_FRONT, 32'h00000001, 10'h2aa, 10'h155}, 1'b0, NO_WANT},
		'{'{FN_PUSH_BACK, 32'h12345678, 10'h2aa, 10'h155}, 1'b0, NO_WANT},
		'{'{FN_REMOVE, 32'h0, 10'h2aa, 10'h155}, 1'b0, NO_WANT},
		'{'{FN_REMOVE, 32'h0, 10'h0, 10'h0}, 1'b0, NO_WANT},
		'{'{FN_CLEAR, 32'h0, 10'h0, 10'h0}, 1'b1, '{32'h0, ST_OK, 7'd0, 1'b1}},
		'{'{FN_CLEAR, 32'hffffffff, 10'h3ff, 10'h3ff}, 1'b1, '{32'h0, ST_OK, 7'd0, 1'b1}},
		'{'{FN_RSVD7, 32'h0, 10'h0, 10'h0}, 1'b1, '{32'h0, ST_OK, 7'd0, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	slot_t held [$];
	rsp_t due_results [$];
	bit failed = 1'b0;
	bit hold_request = 1'b0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int unsigned cycles = 0;

	keyed_deque_store_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	function automatic rsp_t deque_apply(input req_t op);
		rsp_t o;
		slot_t s;
		int hit;
		o = '0;
		o.status = ST_OK;
		s = '{op.item_value, op.pos_x, op.pos_y};
		hit = -1;
		case (op.func)
			FN_PUSH_BACK, FN_PUSH_FRONT: begin
				if (held.size() >= STORE_DEPTH) o.status = ST_FULL;
				else if (op.func == FN_PUSH_BACK) held.push_back(s);
				else held.push_front(s);
			end
			FN_POP_FRONT, FN_POP_BACK: begin
				if (held.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					s = (op.func == FN_POP_FRONT) ? held.pop_front() : held.pop_back();
					o.out_value = s.value;
				end
			end
			FN_REMOVE: begin
				if (held.size() == 0) begin
					o.status = ST_EMPTY;
				end else begin
					foreach (held[i])
						if (hit < 0 && held[i].x == op.pos_x && held[i].y == op.pos_y) hit = i;
					if (hit < 0) begin
						o.status = ST_NOTFOUND;
					end else begin
						o.out_value = held[hit].value;
						held.delete(hit);
					end
				end
			end
			FN_CLEAR: held.delete();
			default: ;
		endcase
		o.entry_count = 7'(held.size());
		o.is_empty = (held.size() == 0);
		return o;
	endfunction

	function automatic req_t make_op(input int mix);
		req_t r;
		int w;
		int k;
		w = $urandom_range(99);
		r.func = FN_RSVD7;
		for (int j = 7; j >= 0; j--)
			if (w < MIX_CUTS[mix][j]) r.func = FUNC_ORDER[j];
		case ($urandom_range(9))
			0: r.item_value = '0;
			1: r.item_value = '1;
			default: r.item_value = $urandom;
		endcase
		if ($urandom_range(1)) begin
			r.pos_x = 10'($urandom_range(3));
			r.pos_y = 10'($urandom_range(3));
		end else begin
			r.pos_x = 10'($urandom_range(1023));
			r.pos_y = 10'($urandom_range(1023));
		end
		if (r.func == FN_REMOVE && held.size() > 0 && $urandom_range(99) < 70) begin
			k = $urandom_range(held.size() - 1);
			r.pos_x = held[k].x;
			r.pos_y = held[k].y;
		end
		return r;
	endfunction

	task automatic send_op(input req_t op, input logic typed, input rsp_t want);
		rsp_t exp;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= op;
		do @(posedge clk); while (req_stall);
		exp = deque_apply(op);
		due_results.push_back(typed ? want : exp);
	endtask

	task automatic await_results();
		req_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int n, input int idle, input int stall, input int mix);
		send_idle_pct = idle;
		stall_pct = stall;
		repeat (n) send_op(make_op(mix), 1'b0, NO_WANT);
		await_results();
	endtask

	task automatic check_result(input rsp_t want, input rsp_t got);
		if (got.out_value !== want.out_value) begin
			$display("%0t: out_value expected %h, actual %h", $time, want.out_value, got.out_value);
			failed = 1'b1;
		end
		if (got.status !== want.status) begin
			$display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
			failed = 1'b1;
		end
		if (got.entry_count !== want.entry_count) begin
			$display("%0t: entry_count expected %0d, actual %0d", $time, want.entry_count,
				got.entry_count);
			failed = 1'b1;
		end
		if (got.is_empty !== want.is_empty) begin
			$display("%0t: is_empty expected %b, actual %b", $time, want.is_empty, got.is_empty);
			failed = 1'b1;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result transfer, expected none, actual %h", $time, rsp);
				failed = 1'b1;
			end else begin
				check_result(due_results.pop_front(), rsp);
			end
		end
	end

	// The long hold-off is timed here so that the sender keeps offering transfers meanwhile.
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i]) send_op(DIRECTED[i].op, DIRECTED[i].typed, DIRECTED[i].want);
		await_results();
		run_phase(300, 0, 0, MIX_EVEN);
		run_phase(250, 0, 0, MIX_FILL);
		run_phase(250, 85, 0, MIX_EVEN);
		run_phase(200, 0, 85, MIX_FILL);
		run_phase(250, 0, 85, MIX_DRAIN);
		hold_request = 1'b1;
		run_phase(200, 0, 0, MIX_FILL);
		run_phase(250, 35, 35, MIX_EVEN);
		run_phase(150, 35, 35, MIX_DRAIN);
		run_phase(150, 85, 85, MIX_FILL);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
